// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by console_mailbox_keepalive_core.sv.
// ASSERT_RST disables the check while the reset input is high.
// ASSERT_ALWAYS checks at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/ckm_pkg.sv =====
package ckm_pkg;

   localparam int NumWords = 5;
   localparam int WordW    = 36;
   localparam int SelW     = 3;
   localparam int FuncW    = 3;
   localparam int KeyW     = 8;
   localparam int CharW    = 7;
   localparam int LimitW   = 8;
   localparam int CountW   = 8;
   localparam int AliveLsb = 8;
   localparam int AliveW   = 8;
   localparam int ReasonW  = 8;

   // request codes
   localparam logic [FuncW-1:0] FuncHostWr    = 3'd0;
   localparam logic [FuncW-1:0] FuncHostRd    = 3'd1;
   localparam logic [FuncW-1:0] FuncDoorbell  = 3'd2;
   localparam logic [FuncW-1:0] FuncPrintDone = 3'd3;
   localparam logic [FuncW-1:0] FuncKey       = 3'd4;
   localparam logic [FuncW-1:0] FuncTick      = 3'd5;

   // mailbox word slots
   localparam logic [SelW-1:0] SelKeepAlive = 3'd0;
   localparam logic [SelW-1:0] SelTtyIn     = 3'd1;
   localparam logic [SelW-1:0] SelTtyOut    = 3'd2;

   // bit positions in the mailbox words
   localparam int ValidBit  = 8;
   localparam int ReloadBit = 31;
   localparam int ActiveBit = 30;

   localparam logic [WordW-1:0] ReloadClr   = 36'o0030000177777;
   localparam logic [WordW-1:0] ReasonField = 36'o0000000000377;
   localparam logic [WordW-1:0] KaReset     = 36'o0003740000000;

   localparam logic [ReasonW-1:0] RsnForced = 8'o002;
   localparam logic [ReasonW-1:0] RsnKaFail = 8'o001;

   localparam logic [LimitW-1:0] LimitReset = 8'd15;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [SelW-1:0]  word_select;
      logic [WordW-1:0] write_data;
      logic [KeyW-1:0]  key_code;
      logic             key_break;
   } req_type;

   typedef struct packed {
      logic [WordW-1:0] read_data;
      logic             console_irq;
      logic             print_start;
      logic [CharW-1:0] print_char;
      logic             poll_request;
      logic             key_taken;
      logic             reload_request;
      logic             keepalive_fail;
   } rsp_type;

   typedef struct packed {
      logic [NumWords-1:0][WordW-1:0] words;
      logic [AliveW-1:0]              last_alive;
      logic [CountW-1:0]              unchanged;
   } state_type;

endpackage

// ===== rtl/ckm_req_if.sv =====
interface ckm_req_if;
   logic                       valid;
   logic                       ready;
   logic [ckm_pkg::FuncW-1:0]  func;
   logic [ckm_pkg::SelW-1:0]   word_select;
   logic [ckm_pkg::WordW-1:0]  write_data;
   logic [ckm_pkg::KeyW-1:0]   key_code;
   logic                       key_break;

   modport source (
      output valid, func, word_select, write_data, key_code, key_break,
      input  ready
   );

   modport sink (
      input  valid, func, word_select, write_data, key_code, key_break,
      output ready
   );
endinterface

// ===== rtl/ckm_rsp_if.sv =====
interface ckm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ckm_pkg::WordW-1:0]  read_data;
   logic                       console_irq;
   logic                       print_start;
   logic [ckm_pkg::CharW-1:0]  print_char;
   logic                       poll_request;
   logic                       key_taken;
   logic                       reload_request;
   logic                       keepalive_fail;

   modport source (
      output valid, read_data, console_irq, print_start, print_char,
             poll_request, key_taken, reload_request, keepalive_fail,
      input  ready
   );

   modport sink (
      input  valid, read_data, console_irq, print_start, print_char,
             poll_request, key_taken, reload_request, keepalive_fail,
      output ready
   );
endinterface

// ===== rtl/ckm_step.sv =====
// Next-state and result for one word, pure combinational.
module ckm_step (
   input  ckm_pkg::req_type                item,
   input  ckm_pkg::state_type              cur,
   input  logic [ckm_pkg::LimitW-1:0]      limit,
   output ckm_pkg::state_type              nxt,
   output ckm_pkg::rsp_type                res
);

   logic                              sel_ok;
   logic [ckm_pkg::WordW-1:0]         w0;
   logic [ckm_pkg::WordW-1:0]         w1;
   logic [ckm_pkg::WordW-1:0]         w2;
   logic [ckm_pkg::AliveW-1:0]        alive;
   logic [ckm_pkg::CountW-1:0]        count_inc;

   assign sel_ok    = item.word_select < ckm_pkg::SelW'(ckm_pkg::NumWords);
   assign w0        = cur.words[ckm_pkg::SelKeepAlive];
   assign w1        = cur.words[ckm_pkg::SelTtyIn];
   assign w2        = cur.words[ckm_pkg::SelTtyOut];
   assign alive     = w0[ckm_pkg::AliveLsb +: ckm_pkg::AliveW];
   assign count_inc = cur.unchanged + ckm_pkg::CountW'(1);

   always_comb begin
      nxt = cur;
      res = '0;
      unique case (item.func)
         ckm_pkg::FuncHostWr: begin
            if (sel_ok) begin
               nxt.words[item.word_select] = item.write_data;
            end
         end
         ckm_pkg::FuncHostRd: begin
            if (sel_ok) begin
               res.read_data = cur.words[item.word_select];
            end
         end
         ckm_pkg::FuncDoorbell: begin
            if (w2[ckm_pkg::ValidBit]) begin
               res.print_start = 1'b1;
               res.print_char  = w2[ckm_pkg::CharW-1:0];
            end else if (!w1[ckm_pkg::ValidBit]) begin
               res.poll_request = 1'b1;
            end
         end
         ckm_pkg::FuncPrintDone: begin
            nxt.words[ckm_pkg::SelTtyOut] = '0;
            res.console_irq = 1'b1;
         end
         ckm_pkg::FuncKey: begin
            // hold the key while the host has not taken the last one
            if (!w1[ckm_pkg::ValidBit]) begin
               res.key_taken = 1'b1;
               if (!item.key_break) begin
                  nxt.words[ckm_pkg::SelTtyIn] =
                     ckm_pkg::WordW'(item.key_code[ckm_pkg::CharW-1:0]);
                  nxt.words[ckm_pkg::SelTtyIn][ckm_pkg::ValidBit] = 1'b1;
                  res.console_irq = 1'b1;
               end
            end
         end
         ckm_pkg::FuncTick: begin
            if (w0[ckm_pkg::ReloadBit]) begin
               nxt.words[ckm_pkg::SelKeepAlive] =
                  (w0 & ~ckm_pkg::ReloadClr) | ckm_pkg::WordW'(ckm_pkg::RsnForced);
               for (int i = 1; i < ckm_pkg::NumWords; i++) begin
                  nxt.words[i] = '0;
               end
               res.reload_request = 1'b1;
            end else if (w0[ckm_pkg::ActiveBit]) begin
               if (alive != cur.last_alive) begin
                  nxt.last_alive = alive;
                  nxt.unchanged  = '0;
               end else if (count_inc >= limit) begin
                  nxt.unchanged = '0;
                  nxt.words[ckm_pkg::SelKeepAlive] =
                     (w0 & ~ckm_pkg::ReasonField) | ckm_pkg::WordW'(ckm_pkg::RsnKaFail);
                  for (int i = 1; i < ckm_pkg::NumWords; i++) begin
                     nxt.words[i] = '0;
                  end
                  res.keepalive_fail = 1'b1;
               end else begin
                  nxt.unchanged = count_inc;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/console_mailbox_keepalive_core.sv =====
// Console mailbox front end with keep-alive watchdog. Each request word on
// req_chan (host write/read, doorbell, print done, key arrival, one-second
// tick) yields exactly one response word on rsp_chan, in order. The block
// sustains one word per clock while rsp_chan does not stall: a word is held in
// the input register, is evaluated by a single pass of short logic against the
// five 36-bit mailbox words and watchdog counters, and lands in the response
// register, which drives rsp_chan.valid. Throughput is set only by the
// response register: req_chan.ready stays high while the input register can
// move on, and drops only when a response is stalled and the input register
// is full. csr_wr_data loads the keep-alive limit (seconds without change of
// the alive field before failure, reset 15); write it only while no words are
// in flight. Reset is synchronous; no clearing pass is needed.
`include "assert_macros.svh"

module console_mailbox_keepalive_core (
   input  logic                        clock,
   input  logic                        reset,
   ckm_req_if.sink                     req_chan,
   ckm_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [ckm_pkg::LimitW-1:0]  csr_wr_data
);

   // input register
   logic                         s1_vld_ff;
   logic                         s1_vld_in;
   ckm_pkg::req_type             s1_item_ff;
   ckm_pkg::req_type             req_word;

   // response register
   logic                         rsp_vld_ff;
   logic                         rsp_vld_in;
   ckm_pkg::rsp_type             rsp_data_ff;

   // block state
   ckm_pkg::state_type           state_ff;
   ckm_pkg::state_type           state_in;
   ckm_pkg::rsp_type             step_res;
   logic [ckm_pkg::LimitW-1:0]   limit_ff;

   logic                         req_accept;
   logic                         advance;

   assign req_word.func        = req_chan.func;
   assign req_word.word_select = req_chan.word_select;
   assign req_word.write_data  = req_chan.write_data;
   assign req_word.key_code    = req_chan.key_code;
   assign req_word.key_break   = req_chan.key_break;

   // move the input word into the response register when that slot frees up
   assign advance        = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   ckm_step u_step (
      .item  (s1_item_ff),
      .cur   (state_ff),
      .limit (limit_ff),
      .nxt   (state_in),
      .res   (step_res)
   );

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff           <= 1'b0;
         rsp_vld_ff          <= 1'b0;
         // keep-alive word sits in the low slot, the others clear
         state_ff.words      <= (ckm_pkg::NumWords*ckm_pkg::WordW)'(ckm_pkg::KaReset);
         state_ff.last_alive <= '0;
         state_ff.unchanged  <= '0;
         limit_ff            <= ckm_pkg::LimitReset;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_word;
      end
      if (advance) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.read_data      = rsp_data_ff.read_data;
   assign rsp_chan.console_irq    = rsp_data_ff.console_irq;
   assign rsp_chan.print_start    = rsp_data_ff.print_start;
   assign rsp_chan.print_char     = rsp_data_ff.print_char;
   assign rsp_chan.poll_request   = rsp_data_ff.poll_request;
   assign rsp_chan.key_taken      = rsp_data_ff.key_taken;
   assign rsp_chan.reload_request = rsp_data_ff.reload_request;
   assign rsp_chan.keepalive_fail = rsp_data_ff.keepalive_fail;

   // a word in the input register reaches an empty response slot next cycle
   `ASSERT_RST(a_fill_rsp, clock, reset, (s1_vld_ff && !rsp_vld_ff) |=> rsp_vld_ff, "input word did not advance")
   // the input side stalls only when the response is stuck
   `ASSERT_RST(a_stall, clock, reset, (s1_vld_ff && rsp_vld_ff && !rsp_chan.ready) |-> !req_chan.ready, "accepted while full")
   // the event flags of one response exclude each other
   `ASSERT_RST(a_flags, clock, reset, rsp_vld_ff |-> $onehot0({rsp_data_ff.print_start, rsp_data_ff.poll_request, rsp_data_ff.key_taken, rsp_data_ff.reload_request, rsp_data_ff.keepalive_fail}), "conflicting event flags")
   // a watchdog failure restarts the count
   `ASSERT_RST(a_kfail_cnt, clock, reset, (advance && step_res.keepalive_fail) |=> (state_ff.unchanged == '0), "count not cleared on failure")
   // reset restores the keep-alive word
   `ASSERT_ALWAYS(a_ka_reset, clock, $past(reset) |-> (state_ff.words[ckm_pkg::SelKeepAlive] == ckm_pkg::KaReset), "keep-alive reset value")

endmodule
